// File: sv/serial_frame_receiver_crc8_macros.svh
// assertion macros for the serial frame receiver
// no dependencies; taken in by the modules that carry assertions
`ifndef SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SFR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr: next-cycle check failed");

`endif

// File: sv/sfr_pkg.sv
// types, constants and the crc-8 update for the serial frame receiver
// no dependencies
package sfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned ID_W       = 6;
   localparam int unsigned TYPE_W     = 2;
   localparam int unsigned NUM_LEN    = 4;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h1D;
   localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
   localparam logic [ID_W-1:0]   ID_MIN     = 6'd1;
   localparam logic [ID_W-1:0]   ID_MAX     = 6'd4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_LEN_ID1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_ID2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_ID3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_ID4 = 3'd3;

   localparam logic [BYTE_W-1:0] LEN_ID1_RST = 8'd96;
   localparam logic [BYTE_W-1:0] LEN_ID2_RST = 8'd1;
   localparam logic [BYTE_W-1:0] LEN_ID3_RST = 8'd3;
   localparam logic [BYTE_W-1:0] LEN_ID4_RST = 8'd10;

   typedef logic [NUM_LEN-1:0][BYTE_W-1:0] len_tbl_type;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_ID   = 5'b00010,
      PH_LEN  = 5'b00100,
      PH_BODY = 5'b01000,
      PH_CRC  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] body_byte;
      logic [BYTE_W-1:0] body_index;
      logic [ID_W-1:0]   msg_id;
      logic [TYPE_W-1:0] msg_type;
      logic              frame_end;
      logic              crc_good;
   } rsp_type;

   // msb-first crc-8, one byte
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: sv/serial_frame_receiver_crc8.sv
// serial frame receiver: start byte, id/type, length, body, crc-8 check
// request channel carries one received byte on req_rx_byte with req_valid/req_ready.
// each body byte comes out on the rsp_ channel with its index, id and type;
// the crc byte ends the frame with rsp_frame_end set and rsp_crc_good giving
// the check result (crc-8 poly 0x1d, init 0, over start, id, length and body).
// start, id and length bytes, and bytes seen while hunting, give no response.
// csr_ port: four expected-length registers (ids 1 to 4), written with
// csr_wr_en; indexes beyond them are ignored. write only while idle.
// an accepted request is held in the input byte register and its response is
// then loaded into the result register (two register stages: input byte, result).
// throughput: one request per cycle unless a stalled result holds the input; the
// parser state update for one byte is combinational logic, crc included.
// reset clears the parser to hunting, empties both stages and loads the
// length registers with 96, 1, 3 and 10.
// when rsp_ready is low the result waits in its register; the input stage
// still moves bytes that give no response, and req_ready drops only when a
// byte that would respond is held behind a pending result.
// depends on sfr_pkg, sfr_cfg_regs, sfr_parser, sfr_rsp_reg
module serial_frame_receiver_crc8 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]         rsp_body_byte,
   output logic [sfr_pkg::BYTE_W-1:0]         rsp_body_index,
   output logic [sfr_pkg::ID_W-1:0]           rsp_msg_id,
   output logic [sfr_pkg::TYPE_W-1:0]         rsp_msg_type,
   output logic                               rsp_frame_end,
   output logic                               rsp_crc_good,
   input  logic                               csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]         csr_wdata
);

   logic                         in_vld_ff, in_vld_in;
   logic [sfr_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         advance;
   logic                         emit;
   logic                         req_take;
   sfr_pkg::len_tbl_type         len_tbl;
   sfr_pkg::rsp_type             parse_rsp;
   sfr_pkg::rsp_type             rsp_data;

   // held byte moves on unless it responds into a stalled result register
   assign advance   = in_vld_ff && (!emit || !rsp_valid || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfr_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .len_tbl   (len_tbl)
   );

   sfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .len_tbl (len_tbl),
      .emit    (emit),
      .rsp     (parse_rsp)
   );

   sfr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (parse_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_body_byte  = rsp_data.body_byte;
   assign rsp_body_index = rsp_data.body_index;
   assign rsp_msg_id     = rsp_data.msg_id;
   assign rsp_msg_type   = rsp_data.msg_type;
   assign rsp_frame_end  = rsp_data.frame_end;
   assign rsp_crc_good   = rsp_data.crc_good;

endmodule

// File: sv/sfr_cfg_regs.sv
// expected body length registers, one per message id
// depends on sfr_pkg
module sfr_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]        csr_wdata,
   output sfr_pkg::len_tbl_type              len_tbl
);

   sfr_pkg::len_tbl_type len_ff;
   sfr_pkg::len_tbl_type len_in;

   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sfr_pkg::REG_LEN_ID1: len_in[0] = csr_wdata;
            sfr_pkg::REG_LEN_ID2: len_in[1] = csr_wdata;
            sfr_pkg::REG_LEN_ID3: len_in[2] = csr_wdata;
            sfr_pkg::REG_LEN_ID4: len_in[3] = csr_wdata;
            default: len_in = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[0] <= sfr_pkg::LEN_ID1_RST;
         len_ff[1] <= sfr_pkg::LEN_ID2_RST;
         len_ff[2] <= sfr_pkg::LEN_ID3_RST;
         len_ff[3] <= sfr_pkg::LEN_ID4_RST;
      end else begin
         len_ff <= len_in;
      end
   end

   assign len_tbl = len_ff;

endmodule

// File: sv/sfr_parser.sv
// frame parser state machine with running crc-8
// depends on sfr_pkg and serial_frame_receiver_crc8_macros.svh
`include "serial_frame_receiver_crc8_macros.svh"

module sfr_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [sfr_pkg::BYTE_W-1:0]   rx_byte,
   input  sfr_pkg::len_tbl_type         len_tbl,
   output logic                         emit,
   output sfr_pkg::rsp_type             rsp
);

   sfr_pkg::phase_type             phase_ff, phase_in;
   logic [sfr_pkg::ID_W-1:0]       frame_id_ff, frame_id_in;
   logic [sfr_pkg::TYPE_W-1:0]     frame_type_ff, frame_type_in;
   logic [sfr_pkg::BYTE_W-1:0]     frame_len_ff, frame_len_in;
   logic [sfr_pkg::BYTE_W-1:0]     body_count_ff, body_count_in;
   logic [sfr_pkg::BYTE_W-1:0]     crc_ff, crc_in;
   logic [sfr_pkg::BYTE_W-1:0]     expected_len;
   logic [sfr_pkg::ID_W-1:0]       rx_id;
   logic                           id_ok;
   logic [sfr_pkg::BYTE_W-1:0]     crc_next;

   assign rx_id    = rx_byte[sfr_pkg::ID_W-1:0];
   assign id_ok    = (rx_id >= sfr_pkg::ID_MIN) && (rx_id <= sfr_pkg::ID_MAX);
   assign crc_next = sfr_pkg::crc8_update(crc_ff, rx_byte);

   always_comb begin
      case (frame_id_ff)
         6'd1:    expected_len = len_tbl[0];
         6'd2:    expected_len = len_tbl[1];
         6'd3:    expected_len = len_tbl[2];
         default: expected_len = len_tbl[3];
      endcase
   end

   assign emit = (phase_ff == sfr_pkg::PH_BODY) || (phase_ff == sfr_pkg::PH_CRC);

   always_comb begin
      phase_in       = phase_ff;
      frame_id_in    = frame_id_ff;
      frame_type_in  = frame_type_ff;
      frame_len_in   = frame_len_ff;
      body_count_in  = body_count_ff;
      crc_in         = crc_ff;
      rsp.body_byte  = rx_byte;
      rsp.body_index = body_count_ff;
      rsp.msg_id     = frame_id_ff;
      rsp.msg_type   = frame_type_ff;
      rsp.frame_end  = 1'b0;
      rsp.crc_good   = 1'b0;
      case (phase_ff)
         sfr_pkg::PH_ID: begin
            if (id_ok) begin
               frame_id_in   = rx_id;
               frame_type_in = rx_byte[sfr_pkg::BYTE_W-1 -: sfr_pkg::TYPE_W];
               crc_in        = crc_next;
               phase_in      = sfr_pkg::PH_LEN;
            end else begin
               phase_in = sfr_pkg::PH_HUNT;
            end
         end
         sfr_pkg::PH_LEN: begin
            if (rx_byte == expected_len) begin
               frame_len_in  = rx_byte;
               body_count_in = '0;
               crc_in        = crc_next;
               phase_in      = (rx_byte == '0) ? sfr_pkg::PH_CRC : sfr_pkg::PH_BODY;
            end else begin
               phase_in = sfr_pkg::PH_HUNT;
            end
         end
         sfr_pkg::PH_BODY: begin
            crc_in        = crc_next;
            body_count_in = sfr_pkg::BYTE_W'(body_count_ff + 8'd1);
            if (body_count_in == frame_len_ff) begin
               phase_in = sfr_pkg::PH_CRC;
            end
         end
         sfr_pkg::PH_CRC: begin
            rsp.body_index = frame_len_ff;
            rsp.frame_end  = 1'b1;
            rsp.crc_good   = (rx_byte == crc_ff);
            phase_in       = sfr_pkg::PH_HUNT;
         end
         default: begin
            phase_in = sfr_pkg::PH_HUNT;
            if (rx_byte == sfr_pkg::START_BYTE) begin
               crc_in   = sfr_pkg::crc8_update(sfr_pkg::CRC_INIT, rx_byte);
               phase_in = sfr_pkg::PH_ID;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sfr_pkg::PH_HUNT;
         frame_id_ff   <= '0;
         frame_type_ff <= '0;
         frame_len_ff  <= '0;
         body_count_ff <= '0;
         crc_ff        <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         frame_id_ff   <= frame_id_in;
         frame_type_ff <= frame_type_in;
         frame_len_ff  <= frame_len_in;
         body_count_ff <= body_count_in;
         crc_ff        <= crc_in;
      end
   end

   // crc byte always closes the frame
   `SFR_ASSERT_NEXT(a_crc_closes, clock, reset, advance && (phase_ff == sfr_pkg::PH_CRC), phase_ff == sfr_pkg::PH_HUNT)
   // body index never reaches the frame length
   `SFR_ASSERT_IMPL(a_body_in_range, clock, reset, phase_ff == sfr_pkg::PH_BODY, body_count_ff < frame_len_ff)
   // length mismatch drops the frame
   `SFR_ASSERT_NEXT(a_len_reject, clock, reset, advance && (phase_ff == sfr_pkg::PH_LEN) && (rx_byte != expected_len), phase_ff == sfr_pkg::PH_HUNT)
   // bad id drops the frame
   `SFR_ASSERT_NEXT(a_id_reject, clock, reset, advance && (phase_ff == sfr_pkg::PH_ID) && !id_ok, phase_ff == sfr_pkg::PH_HUNT)

endmodule

// File: sv/sfr_rsp_reg.sv
// result register for the response channel
// depends on sfr_pkg
module sfr_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sfr_pkg::rsp_type  load_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output sfr_pkg::rsp_type  rsp_data
);

   logic             vld_ff, vld_in;
   sfr_pkg::rsp_type data_ff;

   always_comb begin
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule
